/* rtl/core/assert_macros.svh */
// Assertion macros used by the back end RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked assertion, disabled while in reset.
`define KDST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Implication checked on the following edge.
`define KDST_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

/* rtl/core/kdst_pkg.sv */
// Shared types, constants and state codes of the keyed duration statistics block.
package kdst_pkg;
  localparam int SlotCountDef = 40;
  localparam logic [5:0] TopCountRst = 6'd12;

  typedef struct packed {
    logic        req;
    logic [31:0] key;
    logic [31:0] elapsed;
  } kdst_cmd_t;

  typedef struct packed {
    logic [63:0] total;
    logic [31:0] maxv;
    logic [31:0] cnt;
  } kdst_stat_t;

  typedef struct packed {
    logic [31:0] key;
    logic [63:0] total;
    logic [31:0] maxv;
    logic [31:0] cnt;
    logic        other;
    logic        last;
  } kdst_res_t;

  typedef enum logic [3:0] {
    B_IDLE, R_KRD, R_KCMP, R_MISS,
    P_INIT, P_SEL_RD, P_SEL_CMP, P_SEL_DONE, P_EMIT,
    P_FOLD_RD, P_FOLD_ADD, P_OTHER, P_FLUSH, P_CLR
  } kdst_state_t;

  localparam logic REQ_RECORD = 1'b0;
  localparam logic REQ_REPORT = 1'b1;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction
endpackage

/* rtl/core/kdst_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kdst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 40
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/core/kdst_front.sv */
// Front end: accepts items, drops keyless records, works out elapsed time, queues commands.
module kdst_front import kdst_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_stage_key,
  input  logic [31:0] in_start_stamp,
  input  logic [31:0] in_end_stamp,
  output logic        cmd_valid,
  output kdst_cmd_t   cmd,
  input  logic        cmd_pop
);
  kdst_cmd_t   q_r [2];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        rd_r, wr_r;
  logic        push;

  assign busy      = (cnt_r == 2'd2);
  assign push      = start && !busy && ((in_req_type == REQ_REPORT) || (in_stage_key != '0));
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !(cmd_pop && cmd_valid)) cnt_nxt = cnt_r + 2'd1;
    else if (!push && cmd_pop && cmd_valid) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (cmd_pop && cmd_valid) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_r] <= '{req: in_req_type, key: in_stage_key,
                     elapsed: in_end_stamp - in_start_stamp};
    end
  end
endmodule

/* rtl/core/kdst_back.sv */
// Back end: slot table lookup and update, ranked report, statistics clear.
`include "assert_macros.svh"
module kdst_back import kdst_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cmd_valid,
  input  kdst_cmd_t   cmd,
  output logic        cmd_pop,
  input  logic [5:0]  top_count,
  output logic        out_valid,
  output kdst_res_t   out_res
);
  localparam int IW = $clog2(SLOT_COUNT > 1 ? SLOT_COUNT : 2);
  localparam int CW = $clog2(SLOT_COUNT + 1);

  kdst_state_t state_r, state_nxt;
  kdst_cmd_t   cmd_r, cmd_nxt;
  logic [CW-1:0] idx_r, idx_nxt, used_r, used_nxt, rank_r, rank_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic [63:0]   best_tot_r, best_tot_nxt;
  logic          found_r, found_nxt;
  logic [SLOT_COUNT-1:0] picked_r, picked_nxt;
  kdst_stat_t    oth_r, oth_nxt, ovf_r, ovf_nxt;
  logic          pend_v_r, pend_v_nxt, out_v_r, out_v_nxt;
  kdst_res_t     pend_r, pend_nxt, out_r, out_nxt;

  logic          key_we, stat_we;
  logic [IW-1:0] waddr, raddr;
  logic [31:0]   key_wd, key_rd;
  kdst_stat_t    stat_wd, stat_rd;
  logic          more_ranks, scan_end;

  kdst_ram #(.WIDTH(32), .DEPTH(SLOT_COUNT)) u_keys (
    .clk(clk), .we(key_we), .waddr(waddr), .wdata(key_wd), .raddr(raddr), .rdata(key_rd));
  kdst_ram #(.WIDTH($bits(kdst_stat_t)), .DEPTH(SLOT_COUNT)) u_stats (
    .clk(clk), .we(stat_we), .waddr(waddr), .wdata(stat_wd), .raddr(raddr), .rdata(stat_rd));

  assign more_ranks = (8'(rank_nxt) < 8'(top_count)) && (rank_nxt < used_r);
  assign scan_end   = (idx_r == used_r);
  assign raddr      = (state_r == P_SEL_DONE) ? best_r : idx_r[IW-1:0];
  assign out_valid  = out_v_r;
  assign out_res    = out_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_IDLE:     if (cmd_valid) state_nxt = (cmd.req == REQ_REPORT) ? P_INIT : R_KRD;
      R_KRD:      state_nxt = scan_end ? R_MISS : R_KCMP;
      R_KCMP:     state_nxt = (key_rd == cmd_r.key) ? B_IDLE : R_KRD;
      R_MISS:     state_nxt = B_IDLE;
      P_INIT:     state_nxt = more_ranks ? P_SEL_RD : P_FOLD_RD;
      P_SEL_RD:   state_nxt = scan_end ? P_SEL_DONE : P_SEL_CMP;
      P_SEL_CMP:  state_nxt = P_SEL_RD;
      P_SEL_DONE: state_nxt = P_EMIT;
      P_EMIT:     state_nxt = more_ranks ? P_SEL_RD : P_FOLD_RD;
      P_FOLD_RD:  state_nxt = scan_end ? P_OTHER : P_FOLD_ADD;
      P_FOLD_ADD: state_nxt = P_FOLD_RD;
      P_OTHER:    state_nxt = P_FLUSH;
      P_FLUSH:    state_nxt = P_CLR;
      P_CLR:      state_nxt = scan_end ? B_IDLE : P_CLR;
      default:    state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    kdst_res_t res;
    logic      push;
    cmd_nxt = cmd_r; idx_nxt = idx_r; used_nxt = used_r; rank_nxt = rank_r;
    best_nxt = best_r; best_tot_nxt = best_tot_r; found_nxt = found_r;
    picked_nxt = picked_r; oth_nxt = oth_r; ovf_nxt = ovf_r;
    pend_v_nxt = pend_v_r; pend_nxt = pend_r; out_v_nxt = 1'b0; out_nxt = out_r;
    cmd_pop = 1'b0; key_we = 1'b0; stat_we = 1'b0;
    waddr = idx_r[IW-1:0]; key_wd = cmd_r.key; stat_wd = stat_rd;
    res = '0; push = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          idx_nxt = '0;
        end
      end
      R_KCMP: begin
        if (key_rd == cmd_r.key) begin
          stat_we       = 1'b1;
          stat_wd.total = stat_rd.total + 64'(cmd_r.elapsed);
          stat_wd.maxv  = (cmd_r.elapsed > stat_rd.maxv) ? cmd_r.elapsed : stat_rd.maxv;
          stat_wd.cnt   = sat_add(stat_rd.cnt, 32'd1);
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      R_MISS: begin
        if (used_r < CW'(SLOT_COUNT)) begin
          // allocate the next free slot
          waddr    = used_r[IW-1:0];
          key_we   = 1'b1;
          stat_we  = 1'b1;
          stat_wd  = '{total: 64'(cmd_r.elapsed), maxv: cmd_r.elapsed, cnt: 32'd1};
          used_nxt = used_r + CW'(1);
        end else begin
          ovf_nxt.total = ovf_r.total + 64'(cmd_r.elapsed);
          ovf_nxt.maxv  = (cmd_r.elapsed > ovf_r.maxv) ? cmd_r.elapsed : ovf_r.maxv;
          ovf_nxt.cnt   = sat_add(ovf_r.cnt, 32'd1);
        end
      end
      P_INIT: begin
        rank_nxt   = '0;
        picked_nxt = '0;
        found_nxt  = 1'b0;
        idx_nxt    = '0;
        oth_nxt    = ovf_r;
        pend_v_nxt = 1'b0;
      end
      P_SEL_CMP: begin
        // strict compare keeps ties on the lower slot
        if (!picked_r[idx_r[IW-1:0]] && (!found_r || stat_rd.total > best_tot_r)) begin
          found_nxt    = 1'b1;
          best_nxt     = idx_r[IW-1:0];
          best_tot_nxt = stat_rd.total;
        end
        idx_nxt = idx_r + CW'(1);
      end
      P_SEL_DONE: picked_nxt[best_r] = 1'b1;
      P_EMIT: begin
        res  = '{key: key_rd, total: stat_rd.total, maxv: stat_rd.maxv, cnt: stat_rd.cnt,
                 other: 1'b0, last: 1'b0};
        push = (stat_rd.cnt != '0);
        rank_nxt  = rank_r + CW'(1);
        idx_nxt   = '0;
        found_nxt = 1'b0;
      end
      P_FOLD_ADD: begin
        if (!picked_r[idx_r[IW-1:0]]) begin
          oth_nxt.total = oth_r.total + stat_rd.total;
          oth_nxt.maxv  = (stat_rd.maxv > oth_r.maxv) ? stat_rd.maxv : oth_r.maxv;
          oth_nxt.cnt   = sat_add(oth_r.cnt, stat_rd.cnt);
        end
        idx_nxt = idx_r + CW'(1);
      end
      P_OTHER: begin
        res  = '{key: '0, total: oth_r.total, maxv: oth_r.maxv, cnt: oth_r.cnt,
                 other: 1'b1, last: 1'b0};
        push = (oth_r.cnt != '0);
      end
      P_FLUSH: begin
        if (pend_v_r) begin
          out_v_nxt    = 1'b1;
          out_nxt      = pend_r;
          out_nxt.last = 1'b1;
        end
        pend_v_nxt = 1'b0;
        ovf_nxt    = '0;
        idx_nxt    = '0;
      end
      P_CLR: begin
        if (!scan_end) begin
          stat_we = 1'b1;
          stat_wd = '0;
          idx_nxt = idx_r + CW'(1);
        end
      end
      default: ;
    endcase
    if (state_r == P_SEL_RD || state_r == P_FOLD_RD || state_r == R_KRD) begin
      // read issued at idx; advance happens in the compare step
    end
    if (push) begin
      // release the held item, keep the new one until we know whether it is last
      if (pend_v_r) begin
        out_v_nxt = 1'b1;
        out_nxt   = pend_r;
      end
      pend_v_nxt = 1'b1;
      pend_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= B_IDLE;
      used_r   <= '0;
      ovf_r    <= '0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
      idx_r    <= '0;
      rank_r   <= '0;
      found_r  <= 1'b0;
      picked_r <= '0;
    end else begin
      state_r  <= state_nxt;
      used_r   <= used_nxt;
      ovf_r    <= ovf_nxt;
      pend_v_r <= pend_v_nxt;
      out_v_r  <= out_v_nxt;
      idx_r    <= idx_nxt;
      rank_r   <= rank_nxt;
      found_r  <= found_nxt;
      picked_r <= picked_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    best_r     <= best_nxt;
    best_tot_r <= best_tot_nxt;
    oth_r      <= oth_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
  end

  `KDST_ASSERT(a_used_bound, used_r <= CW'(SLOT_COUNT), "slot fill count past table size")
  `KDST_ASSERT(a_out_src, out_v_r |-> ($past(state_r) == P_EMIT ||
    $past(state_r) == P_OTHER || $past(state_r) == P_FLUSH), "result from a non-report state")
  `KDST_ASSERT(a_last_src, (out_v_r && out_r.last) |-> $past(state_r) == P_FLUSH,
    "last flag outside flush")
  `KDST_ASSERT_NEXT(a_rec_quiet, state_r == R_MISS, !out_v_r, "record item produced a result")
endmodule

/* rtl/core/keyed_duration_stats_top_k.sv */
// Record scans the allocated slots for the key; report runs a selection scan over the allocated
// slots for each rank, then a fold scan and a clearing pass over the slot RAM.
// A two-entry command queue lets new items in while the back end works; busy when it is full.
// Results leave one per cycle at most, strobed for one cycle, the receiver cannot stall.
// Synchronous active-low reset empties the table and queue; no clearing pass is needed.
module keyed_duration_stats_top_k import kdst_pkg::*; #(
  parameter int SLOT_COUNT = SlotCountDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_req_type,
  input  logic [31:0] in_stage_key,
  input  logic [31:0] in_start_stamp,
  input  logic [31:0] in_end_stamp,
  output logic        out_strobe,
  output logic [31:0] out_entry_key,
  output logic [63:0] out_total_cycles,
  output logic [31:0] out_max_cycles,
  output logic [31:0] out_call_count,
  output logic        out_is_other,
  output logic        out_last_of_report,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [5:0]  cfg_data
);
  logic       cmd_valid, cmd_pop;
  kdst_cmd_t  cmd;
  kdst_res_t  res;
  logic [5:0] top_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r <= TopCountRst;
    end else if (cfg_valid) begin
      top_r <= cfg_data;
    end
  end

  kdst_front u_front (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req_type(in_req_type), .in_stage_key(in_stage_key),
    .in_start_stamp(in_start_stamp), .in_end_stamp(in_end_stamp),
    .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop));

  kdst_back #(.SLOT_COUNT(SLOT_COUNT)) u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(cmd_valid), .cmd(cmd), .cmd_pop(cmd_pop),
    .top_count(top_r), .out_valid(out_strobe), .out_res(res));

  assign out_entry_key      = res.key;
  assign out_total_cycles   = res.total;
  assign out_max_cycles     = res.maxv;
  assign out_call_count     = res.cnt;
  assign out_is_other       = res.other;
  assign out_last_of_report = res.last;
endmodule
